### src/bis_pkg.sv
// Shared types and constants for the bounded stack with top-down search.
// No dependencies; every other file imports this package.
package bis_pkg;

	localparam int DEPTH  = 256;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int POS_W  = 8;
	localparam int OCC_W  = 9;
	localparam int OP_W   = 3;
	localparam int CAP_W  = 9;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_PEEK   = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_SEARCH = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] data;
		logic [POS_W-1:0]  position;
		logic [OCC_W-1:0]  occupancy;
		logic              is_empty;
		logic              is_full;
	} result_t;

endpackage

### src/bis_if.sv
// Channel interfaces for the stack: request, response and capacity write.
// Depends on bis_pkg for field widths.
interface bis_req_if import bis_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, opcode, value, input ready);
	modport sink   (input valid, opcode, value, output ready);
endinterface

interface bis_rsp_if import bis_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] data;
	logic [POS_W-1:0]         position;
	logic [OCC_W-1:0]         occupancy;
	logic                     is_empty;
	logic                     is_full;

	modport source (output valid, status, data, position, occupancy, is_empty, is_full,
		input ready);
	modport sink   (input valid, status, data, position, occupancy, is_empty, is_full,
		output ready);
endinterface

interface bis_cfg_if import bis_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity;

	modport source (output valid, capacity, input ready);
	modport sink   (input valid, capacity, output ready);
endinterface

### src/bis_core.sv
// Stack sequencer: entry memory, occupancy counter and one shared compare unit
// that walks the entries top-down on search. Depends on bis_pkg.
module bis_core import bis_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic [OP_W-1:0]          req_opcode,
	input  logic [DATA_W-1:0]        req_value,
	input  logic [CAP_W-1:0]         capacity,
	output logic                     res_valid,
	input  logic                     res_ready,
	output result_t                  res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_RESP
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    top_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [DATA_W-1:0]   key_q;
	logic [1:0]          status_q;
	logic [DATA_W-1:0]   data_q;
	logic [POS_W-1:0]    pos_q;

	logic [DATA_W-1:0]   mem_q [DEPTH];
	logic [DATA_W-1:0]   rd_q;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_en;

	logic [CNT_W-1:0]    cap_eff;
	logic                push_full;
	logic                req_xfer;
	logic                key_hit;

	// capacity above the store depth is clipped to the depth
	assign cap_eff   = (CNT_W'(capacity) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity);
	assign push_full = (top_q >= cap_eff) || (top_q >= CNT_W'(DEPTH));
	assign req_ready = (state_q == S_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign wr_en     = req_xfer && (req_opcode == OP_PUSH) && !push_full;
	assign key_hit   = (rd_q == key_q);

	// top entry on the accepting cycle, next entry down while scanning
	always_comb begin
		if (state_q == S_SCAN) begin
			rd_addr = idx_q - 1'b1;
		end else begin
			rd_addr = ADDR_W'(top_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[ADDR_W'(top_q)] <= req_value;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
	end

	assign res_valid     = (state_q == S_RESP);
	assign res.status    = status_q;
	assign res.data      = data_q;
	assign res.position  = pos_q;
	assign res.occupancy = OCC_W'(top_q);
	assign res.is_empty  = (top_q == '0);
	assign res.is_full   = (top_q >= cap_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			top_q    <= '0;
			idx_q    <= '0;
			key_q    <= '0;
			status_q <= ST_OK;
			data_q   <= '0;
			pos_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						status_q <= ST_OK;
						data_q   <= '0;
						pos_q    <= '0;
						key_q    <= req_value;
						idx_q    <= ADDR_W'(top_q - 1'b1);
						state_q  <= S_RESP;
						case (req_opcode)
							OP_PUSH: begin
								if (push_full) begin
									status_q <= ST_FULL;
								end else begin
									top_q <= top_q + 1'b1;
								end
							end
							OP_POP, OP_PEEK: begin
								if (top_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									state_q <= S_READ;
									if (req_opcode == OP_POP) begin
										top_q <= top_q - 1'b1;
									end
								end
							end
							OP_CLEAR: begin
								top_q <= '0;
							end
							OP_SEARCH: begin
								if (top_q == '0) begin
									status_q <= ST_NOTFOUND;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					data_q  <= rd_q;
					state_q <= S_RESP;
				end
				S_SCAN: begin
					// rd_q holds the entry at idx_q
					if (key_hit) begin
						pos_q   <= POS_W'(idx_q);
						state_q <= S_RESP;
					end else if (idx_q == '0) begin
						status_q <= ST_NOTFOUND;
						state_q  <= S_RESP;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### src/bounded_int_stack_with_search.sv
// Channel    Dir   Payload                                              Transfer
// req        in    opcode[2:0], value[31:0] signed                      valid & ready
// rsp        out   status, data, position, occupancy, is_empty, is_full valid & ready
// cfg        in    capacity[8:0]                                        valid & ready
//
// Push, clear and unused opcodes go from accept straight to the response state; pop and
// peek pass through a read state first unless the stack is empty. Search steps through
// k entries from the top (1..occupancy) before the response, none on an empty stack;
// one entry per cycle through the single memory read port and key comparator.
// A result sits in the output register while the next request is taken.
// arst_n clears occupancy and sets capacity to 256; entry contents are not reset.
// Top level of the bounded stack. Depends on bis_pkg, bis_if and bis_core.
module bounded_int_stack_with_search import bis_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	bis_req_if.sink  req,
	bis_rsp_if.source rsp,
	bis_cfg_if.sink  cfg
);

	logic [CAP_W-1:0] cap_q;
	logic             out_valid_q;
	result_t          out_q;
	logic             res_valid;
	logic             res_ready;
	logic             core_ready;
	result_t          res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.capacity;
		end
	end

	bis_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (core_ready),
		.req_opcode (req.opcode),
		.req_value  (req.value),
		.capacity   (cap_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	assign req.ready = core_ready;
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_q.status;
	assign rsp.data      = out_q.data;
	assign rsp.position  = out_q.position;
	assign rsp.occupancy = out_q.occupancy;
	assign rsp.is_empty  = out_q.is_empty;
	assign rsp.is_full   = out_q.is_full;

endmodule

### src/bis_checker.sv
// Port-level checks for the bounded stack, bound to the top level.
// Depends on bis_pkg and bounded_int_stack_with_search.
module bis_port_checks import bis_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [1:0]        status,
	input logic [DATA_W-1:0] data,
	input logic [POS_W-1:0]  position,
	input logic [OCC_W-1:0]  occupancy,
	input logic              is_empty,
	input logic              is_full
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(data)
			&& $stable(position) && $stable(occupancy))
		else $error("response changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (occupancy == '0)) && (occupancy <= OCC_W'(DEPTH)))
		else $error("empty flag or occupancy inconsistent");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL) |-> is_full)
		else $error("push refused while not full");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_EMPTY) |-> is_empty && (data == '0) && (position == '0))
		else $error("empty refusal with nonempty stack or data");

endmodule

bind bounded_int_stack_with_search bis_port_checks u_bis_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.status    (rsp.status),
	.data      (rsp.data),
	.position  (rsp.position),
	.occupancy (rsp.occupancy),
	.is_empty  (rsp.is_empty),
	.is_full   (rsp.is_full)
);
